// ===== src/pscsm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pscsm_pkg
// Types, codes and helpers shared by the pedal/steer conditioner modules.
// ----------------------------------------------------------------------------
package pscsm_pkg;

    localparam int SAMPLE_W   = 8;
    localparam int GRADE_W    = 2;
    localparam int BAND_W     = 2;
    localparam int CFG_IDX_W  = 3;

    localparam logic [SAMPLE_W-1:0] SPEED_MAX     = 8'd200;
    localparam logic [SAMPLE_W-1:0] SPEED_MID_MAX = 8'd120;
    localparam logic [SAMPLE_W-1:0] SPEED_LOW_MAX = 8'd60;
    localparam logic [2:0]          ACCEL_GAIN    = 3'd3;
    localparam logic [2:0]          BRAKE_GAIN    = 3'd5;
    localparam int                  FULL_SCALE    = 255;

    // request types
    localparam logic REQ_SEED   = 1'b0;
    localparam logic REQ_UPDATE = 1'b1;

    // delta grades
    localparam logic [GRADE_W-1:0] GRADE_NORMAL   = 2'd0;
    localparam logic [GRADE_W-1:0] GRADE_WARNING  = 2'd1;
    localparam logic [GRADE_W-1:0] GRADE_CRITICAL = 2'd2;

    // speed bands
    localparam logic [BAND_W-1:0] BAND_STOP = 2'd0;
    localparam logic [BAND_W-1:0] BAND_LOW  = 2'd1;
    localparam logic [BAND_W-1:0] BAND_MID  = 2'd2;
    localparam logic [BAND_W-1:0] BAND_HIGH = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BRAKE_WARN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BRAKE_CRIT     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_WARN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_CRIT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STEER_WARN     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STEER_CRIT     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_NOISE_FLOOR    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_PEDAL_DEADZONE = 3'd7;

    typedef struct packed {
        logic                req_type;
        logic [SAMPLE_W-1:0] button_byte;
        logic [SAMPLE_W-1:0] brake_raw;
        logic [SAMPLE_W-1:0] accel_raw;
        logic [SAMPLE_W-1:0] steer_raw;
    } in_item_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] button_out;
        logic [SAMPLE_W-1:0] brake_filt;
        logic [SAMPLE_W-1:0] accel_filt;
        logic [SAMPLE_W-1:0] steer_filt;
        logic [SAMPLE_W-1:0] brake_change;
        logic [GRADE_W-1:0]  brake_grade;
        logic [SAMPLE_W-1:0] accel_change;
        logic [GRADE_W-1:0]  accel_grade;
        logic [SAMPLE_W-1:0] steer_change;
        logic [GRADE_W-1:0]  steer_grade;
        logic [SAMPLE_W-1:0] speed_kph;
        logic [BAND_W-1:0]   speed_band;
    } out_item_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] brake_warn;
        logic [SAMPLE_W-1:0] brake_crit;
        logic [SAMPLE_W-1:0] accel_warn;
        logic [SAMPLE_W-1:0] accel_crit;
        logic [SAMPLE_W-1:0] steer_warn;
        logic [SAMPLE_W-1:0] steer_crit;
        logic [SAMPLE_W-1:0] noise_floor;
        logic [SAMPLE_W-1:0] pedal_deadzone;
    } cfg_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] warn;
        logic [SAMPLE_W-1:0] crit;
        logic [SAMPLE_W-1:0] noise_floor;
    } chan_cfg_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] filt;
        logic [SAMPLE_W-1:0] change;
        logic [GRADE_W-1:0]  grade;
    } chan_res_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] kph;
        logic [BAND_W-1:0]   band;
    } speed_res_t;

    // floor(v * gain / 255) by threshold counting, gain up to 5
    function automatic logic [2:0] scale_255(input logic [SAMPLE_W-1:0] v,
                                             input logic [2:0] gain);
        logic [10:0] prod;
        logic [2:0]  q;
        prod = 11'(v) * 11'(gain);
        q    = 3'd0;
        for (int k = 1; k <= 5; k++) begin
            if (prod >= 11'(FULL_SCALE * k)) begin
                q = q + 3'd1;
            end
        end
        return q;
    endfunction

endpackage

// ===== src/pscsm_chan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pscsm_chan
// One channel: half-step low-pass, delta, noise gate and grading.
// ----------------------------------------------------------------------------
module pscsm_chan (
    input  logic [pscsm_pkg::SAMPLE_W-1:0] prev_lp,
    input  logic [pscsm_pkg::SAMPLE_W-1:0] raw,
    input  logic                           is_pedal,
    input  pscsm_pkg::chan_cfg_t           cfg,
    output pscsm_pkg::chan_res_t           res
);

    logic signed [9:0] diff;
    logic signed [9:0] half;
    logic signed [9:0] sum;
    logic [7:0]        filt;
    logic [7:0]        delta;
    logic [7:0]        gated;

    always_comb begin
        diff = $signed({2'b00, raw}) - $signed({2'b00, prev_lp});
        // halve with truncation toward zero
        if (diff[9]) begin
            half = (diff + 10'sd1) >>> 1;
        end else begin
            half = diff >>> 1;
        end
        sum  = $signed({2'b00, prev_lp}) + half;
        filt = sum[7:0];

        if (filt > prev_lp) begin
            delta = filt - prev_lp;
        end else if (is_pedal) begin
            delta = 8'd0;
        end else begin
            delta = prev_lp - filt;
        end

        gated = (delta < cfg.noise_floor) ? 8'd0 : delta;

        res.filt   = filt;
        res.change = gated;
        priority if (gated >= cfg.crit) begin
            res.grade = pscsm_pkg::GRADE_CRITICAL;
        end else if (gated >= cfg.warn) begin
            res.grade = pscsm_pkg::GRADE_WARNING;
        end else begin
            res.grade = pscsm_pkg::GRADE_NORMAL;
        end
    end

endmodule

// ===== src/pscsm_speed.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pscsm_speed
// Virtual speed step from filtered pedals, clamp and banding.
// ----------------------------------------------------------------------------
module pscsm_speed (
    input  logic [pscsm_pkg::SAMPLE_W-1:0] speed_prev,
    input  logic [pscsm_pkg::SAMPLE_W-1:0] brake_filt,
    input  logic [pscsm_pkg::SAMPLE_W-1:0] accel_filt,
    input  logic [pscsm_pkg::SAMPLE_W-1:0] deadzone,
    output pscsm_pkg::speed_res_t          res
);

    logic [7:0]        accel_dz;
    logic [7:0]        brake_dz;
    logic [2:0]        up;
    logic [2:0]        dn;
    logic signed [9:0] spd;
    logic [7:0]        kph;

    always_comb begin
        accel_dz = (accel_filt > deadzone) ? accel_filt - deadzone : 8'd0;
        brake_dz = (brake_filt > deadzone) ? brake_filt - deadzone : 8'd0;
        up = pscsm_pkg::scale_255(accel_dz, pscsm_pkg::ACCEL_GAIN);
        dn = pscsm_pkg::scale_255(brake_dz, pscsm_pkg::BRAKE_GAIN);

        // drag of one only while moving
        spd = $signed({2'b00, speed_prev}) + $signed({7'd0, up})
            - $signed({7'd0, dn}) - $signed({9'd0, (speed_prev != 8'd0)});

        priority if (spd < 10'sd0) begin
            kph = 8'd0;
        end else if (spd > $signed({2'b00, pscsm_pkg::SPEED_MAX})) begin
            kph = pscsm_pkg::SPEED_MAX;
        end else begin
            kph = spd[7:0];
        end

        res.kph = kph;
        priority if (kph == 8'd0) begin
            res.band = pscsm_pkg::BAND_STOP;
        end else if (kph <= pscsm_pkg::SPEED_LOW_MAX) begin
            res.band = pscsm_pkg::BAND_LOW;
        end else if (kph <= pscsm_pkg::SPEED_MID_MAX) begin
            res.band = pscsm_pkg::BAND_MID;
        end else begin
            res.band = pscsm_pkg::BAND_HIGH;
        end
    end

endmodule

// ===== src/pedal_steer_conditioner_speed_model_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pedal_steer_conditioner_speed_model_top
// Pedal/steer filtering, delta grading and virtual speed, one beat a cycle unless stalled.
// ----------------------------------------------------------------------------
// Path from input beat to result beat: input reg, then result reg.
// Throughput: one beat per cycle unless m_ready stalls; filter and speed
//   state update in the cycle an item moves from input reg to result reg.
// Reset (aresetn low, synchronous): filters and speed cleared, thresholds
//   back to defaults, both stages empty. Config writes always accepted.
// ----------------------------------------------------------------------------
module pedal_steer_conditioner_speed_model_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  pscsm_pkg::in_item_t             s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output pscsm_pkg::out_item_t            m_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [pscsm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pscsm_pkg::SAMPLE_W-1:0]  cfg_data
);

    pscsm_pkg::cfg_t       cfg_reg;
    pscsm_pkg::in_item_t   in_reg;
    logic                  in_valid_reg;
    pscsm_pkg::out_item_t  out_reg, out_next;
    logic                  out_valid_reg;
    logic [7:0]            brake_lp_reg, accel_lp_reg, steer_lp_reg, speed_reg;
    logic                  advance;

    pscsm_pkg::chan_cfg_t  brake_cfg, accel_cfg, steer_cfg;
    pscsm_pkg::chan_res_t  brake_res, accel_res, steer_res;
    pscsm_pkg::speed_res_t speed_res;

    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;

    assign brake_cfg = '{warn: cfg_reg.brake_warn, crit: cfg_reg.brake_crit,
                         noise_floor: cfg_reg.noise_floor};
    assign accel_cfg = '{warn: cfg_reg.accel_warn, crit: cfg_reg.accel_crit,
                         noise_floor: cfg_reg.noise_floor};
    assign steer_cfg = '{warn: cfg_reg.steer_warn, crit: cfg_reg.steer_crit,
                         noise_floor: cfg_reg.noise_floor};

    pscsm_chan u_brake (
        .prev_lp  (brake_lp_reg),
        .raw      (in_reg.brake_raw),
        .is_pedal (1'b1),
        .cfg      (brake_cfg),
        .res      (brake_res)
    );

    pscsm_chan u_accel (
        .prev_lp  (accel_lp_reg),
        .raw      (in_reg.accel_raw),
        .is_pedal (1'b1),
        .cfg      (accel_cfg),
        .res      (accel_res)
    );

    pscsm_chan u_steer (
        .prev_lp  (steer_lp_reg),
        .raw      (in_reg.steer_raw),
        .is_pedal (1'b0),
        .cfg      (steer_cfg),
        .res      (steer_res)
    );

    pscsm_speed u_speed (
        .speed_prev (speed_reg),
        .brake_filt (brake_res.filt),
        .accel_filt (accel_res.filt),
        .deadzone   (cfg_reg.pedal_deadzone),
        .res        (speed_res)
    );

    always_comb begin
        out_next.button_out = in_reg.button_byte;
        if (in_reg.req_type == pscsm_pkg::REQ_SEED) begin
            out_next.brake_filt   = in_reg.brake_raw;
            out_next.accel_filt   = in_reg.accel_raw;
            out_next.steer_filt   = in_reg.steer_raw;
            out_next.brake_change = 8'd0;
            out_next.brake_grade  = pscsm_pkg::GRADE_NORMAL;
            out_next.accel_change = 8'd0;
            out_next.accel_grade  = pscsm_pkg::GRADE_NORMAL;
            out_next.steer_change = 8'd0;
            out_next.steer_grade  = pscsm_pkg::GRADE_NORMAL;
            out_next.speed_kph    = 8'd0;
            out_next.speed_band   = pscsm_pkg::BAND_STOP;
        end else begin
            out_next.brake_filt   = brake_res.filt;
            out_next.accel_filt   = accel_res.filt;
            out_next.steer_filt   = steer_res.filt;
            out_next.brake_change = brake_res.change;
            out_next.brake_grade  = brake_res.grade;
            out_next.accel_change = accel_res.change;
            out_next.accel_grade  = accel_res.grade;
            out_next.steer_change = steer_res.change;
            out_next.steer_grade  = steer_res.grade;
            out_next.speed_kph    = speed_res.kph;
            out_next.speed_band   = speed_res.band;
        end
    end

    // control and state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            brake_lp_reg  <= 8'd0;
            accel_lp_reg  <= 8'd0;
            steer_lp_reg  <= 8'd0;
            speed_reg     <= 8'd0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                brake_lp_reg  <= out_next.brake_filt;
                accel_lp_reg  <= out_next.accel_filt;
                steer_lp_reg  <= out_next.steer_filt;
                speed_reg     <= out_next.speed_kph;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        if (advance) begin
            out_reg <= out_next;
        end
    end

    // register file
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{brake_warn: 8'd8, brake_crit: 8'd20,
                         accel_warn: 8'd8, accel_crit: 8'd20,
                         steer_warn: 8'd30, steer_crit: 8'd90,
                         noise_floor: 8'd15, pedal_deadzone: 8'd10};
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                pscsm_pkg::REG_BRAKE_WARN:     cfg_reg.brake_warn     <= cfg_data;
                pscsm_pkg::REG_BRAKE_CRIT:     cfg_reg.brake_crit     <= cfg_data;
                pscsm_pkg::REG_ACCEL_WARN:     cfg_reg.accel_warn     <= cfg_data;
                pscsm_pkg::REG_ACCEL_CRIT:     cfg_reg.accel_crit     <= cfg_data;
                pscsm_pkg::REG_STEER_WARN:     cfg_reg.steer_warn     <= cfg_data;
                pscsm_pkg::REG_STEER_CRIT:     cfg_reg.steer_crit     <= cfg_data;
                pscsm_pkg::REG_NOISE_FLOOR:    cfg_reg.noise_floor    <= cfg_data;
                pscsm_pkg::REG_PEDAL_DEADZONE: cfg_reg.pedal_deadzone <= cfg_data;
                default: ;
            endcase
        end
    end

endmodule

// ===== src/pscsm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pscsm_checker
// Port-level checks on the conditioner result channel.
// ----------------------------------------------------------------------------
module pscsm_checker (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_valid,
    input logic                 m_ready,
    input pscsm_pkg::out_item_t m_data
);

    // stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat dropped or changed under stall");

    a_empty_after_reset: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_valid)
        else $error("result valid right after reset");

    a_speed_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.speed_kph <= pscsm_pkg::SPEED_MAX)
        else $error("speed out of range");

    a_band: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_data.speed_kph == 8'd0) == (m_data.speed_band == pscsm_pkg::BAND_STOP))
            && ((m_data.speed_kph > pscsm_pkg::SPEED_MID_MAX)
                == (m_data.speed_band == pscsm_pkg::BAND_HIGH)))
        else $error("speed band does not match speed");

    a_grades: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.brake_grade != 2'd3 && m_data.accel_grade != 2'd3
            && m_data.steer_grade != 2'd3)
        else $error("undefined grade code");

endmodule

bind pedal_steer_conditioner_speed_model_top pscsm_checker u_pscsm_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
